/* rtl/core/rpc_pkg.sv */
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the reservoir pump controller
// Payload structs, level and send codes, register indexes and timer sizing.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int TIMER_BITS  = 16;
    localparam int THRESH_BITS = 16;
    localparam int CMP_BITS    = (TIMER_BITS > THRESH_BITS) ? TIMER_BITS : THRESH_BITS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_STABLE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUTTON_STABLE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WELL_ASSIGNED = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WELL_SHARED   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_MANUAL  = 3'd4;

    localparam logic [THRESH_BITS-1:0] LEVEL_STABLE_RESET  = 16'd2000;
    localparam logic [THRESH_BITS-1:0] BUTTON_STABLE_RESET = 16'd50;

    // qualified level codes
    localparam logic [1:0] LVL_UNKNOWN = 2'd0;
    localparam logic [1:0] LVL_EMPTY   = 2'd1;
    localparam logic [1:0] LVL_FULL    = 2'd2;

    // command report codes
    localparam logic [1:0] SEND_NONE   = 2'd0;
    localparam logic [1:0] SEND_DIRECT = 2'd1;
    localparam logic [1:0] SEND_SHARED = 2'd2;

    typedef struct packed {
        logic level_pin_low;
        logic button_pin_low;
    } t_in_item;

    typedef struct packed {
        logic       pump_on;
        logic       mode_manual;
        logic [1:0] level_state;
        logic [1:0] send_kind;
        logic       start_inhibited;
    } t_out_item;

    typedef struct packed {
        logic [THRESH_BITS-1:0] level_stable_ticks;
        logic [THRESH_BITS-1:0] button_stable_ticks;
        logic                   well_assigned;
        logic                   well_shared;
        logic                   start_manual;
    } t_cfg;

    // qualifier results for the control stage
    typedef struct packed {
        logic [1:0] level_now;
        logic       press;
    } t_qual;

    function automatic logic [TIMER_BITS-1:0] timer_inc(input logic [TIMER_BITS-1:0] t);
        logic [TIMER_BITS-1:0] r;
        r = (t == {TIMER_BITS{1'b1}}) ? t : t + 1'b1;
        return r;
    endfunction

    function automatic logic timer_above(input logic [TIMER_BITS-1:0] t,
                                         input logic [THRESH_BITS-1:0] th);
        logic r;
        r = CMP_BITS'(t) > CMP_BITS'(th);
        return r;
    endfunction

endpackage

/* rtl/core/rpc_qualify.sv */
// ----------------------------------------------------------------------------
// rpc_qualify: level qualifier and button debouncer
// Holds the persistence timers; yields the qualified level and press events.
// ----------------------------------------------------------------------------
module rpc_qualify (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  rpc_pkg::t_in_item i_item,
    input  rpc_pkg::t_cfg   i_cfg,
    output rpc_pkg::t_qual  o_qual
);

    logic [1:0]                     r_lvl_cand, n_lvl_cand;
    logic [rpc_pkg::TIMER_BITS-1:0] r_lvl_timer, n_lvl_timer;
    logic [1:0]                     r_lvl_now, n_lvl_now;
    logic                           r_btn_last, n_btn_last;
    logic                           r_btn_steady, n_btn_steady;
    logic [rpc_pkg::TIMER_BITS-1:0] r_btn_timer, n_btn_timer;
    logic                           press;
    logic [1:0]                     detected;

    always_comb begin
        detected = i_item.level_pin_low ? rpc_pkg::LVL_FULL : rpc_pkg::LVL_EMPTY;

        // level: restart persistence on a change of candidate
        n_lvl_cand = detected;
        if (detected != r_lvl_cand) begin
            n_lvl_timer = '0;
        end else begin
            n_lvl_timer = rpc_pkg::timer_inc(r_lvl_timer);
        end
        n_lvl_now = r_lvl_now;
        if (rpc_pkg::timer_above(n_lvl_timer, i_cfg.level_stable_ticks)) begin
            n_lvl_now = detected;
        end

        // button: press is the stable released-to-pressed change
        if (i_item.button_pin_low != r_btn_last) begin
            n_btn_timer = '0;
        end else begin
            n_btn_timer = rpc_pkg::timer_inc(r_btn_timer);
        end
        n_btn_last   = i_item.button_pin_low;
        n_btn_steady = r_btn_steady;
        press        = 1'b0;
        if (rpc_pkg::timer_above(n_btn_timer, i_cfg.button_stable_ticks) &&
            (i_item.button_pin_low != r_btn_steady)) begin
            n_btn_steady = i_item.button_pin_low;
            press        = i_item.button_pin_low;
        end

        o_qual.level_now = n_lvl_now;
        o_qual.press     = press;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_cand   <= rpc_pkg::LVL_UNKNOWN;
            r_lvl_timer  <= '0;
            r_lvl_now    <= rpc_pkg::LVL_UNKNOWN;
            r_btn_last   <= 1'b0;
            r_btn_steady <= 1'b0;
            r_btn_timer  <= '0;
        end else if (i_en) begin
            r_lvl_cand   <= n_lvl_cand;
            r_lvl_timer  <= n_lvl_timer;
            r_lvl_now    <= n_lvl_now;
            r_btn_last   <= n_btn_last;
            r_btn_steady <= n_btn_steady;
            r_btn_timer  <= n_btn_timer;
        end
    end

endmodule

/* rtl/core/rpc_control.sv */
// ----------------------------------------------------------------------------
// rpc_control: mode sequencer and pump command logic
// Applies the press cycle and automatic level control; builds the result.
// ----------------------------------------------------------------------------
module rpc_control (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  rpc_pkg::t_qual     i_qual,
    input  rpc_pkg::t_cfg      i_cfg,
    input  logic               i_mode_load,
    input  logic               i_mode_value,
    output rpc_pkg::t_out_item o_item
);

    logic r_manual, n_manual;
    logic r_pending, n_pending;
    logic r_pump, n_pump;
    logic r_auto_last, n_auto_last;
    logic issued;
    logic inhibited;
    logic want;

    always_comb begin
        n_manual    = r_manual;
        n_pending   = r_pending;
        n_pump      = r_pump;
        n_auto_last = r_auto_last;
        issued      = 1'b0;
        inhibited   = 1'b0;
        want        = r_pump;

        if (i_qual.press) begin
            priority if (!r_manual) begin
                n_manual  = 1'b1;
                n_pending = 1'b1;
            end else if (r_pending) begin
                if (!r_pump && (i_qual.level_now == rpc_pkg::LVL_FULL)) begin
                    inhibited = 1'b1;
                end else begin
                    n_pump = !r_pump;
                    issued = 1'b1;
                end
                n_pending = 1'b0;
            end else begin
                n_manual  = 1'b0;
                n_pending = 1'b0;
            end
        end

        if (!n_manual) begin
            want = n_pump;
            if (i_qual.level_now == rpc_pkg::LVL_EMPTY) begin
                want = 1'b1;
            end else if (i_qual.level_now == rpc_pkg::LVL_FULL) begin
                want = 1'b0;
            end
            if (want != r_auto_last) begin
                n_pump      = want;
                n_auto_last = want;
                issued      = 1'b1;
            end
        end

        o_item.pump_on         = n_pump;
        o_item.mode_manual     = n_manual;
        o_item.level_state     = i_qual.level_now;
        o_item.start_inhibited = inhibited;
        if (issued && i_cfg.well_assigned) begin
            o_item.send_kind = i_cfg.well_shared ? rpc_pkg::SEND_SHARED : rpc_pkg::SEND_DIRECT;
        end else begin
            o_item.send_kind = rpc_pkg::SEND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual    <= 1'b0;
            r_pending   <= 1'b0;
            r_pump      <= 1'b0;
            r_auto_last <= 1'b1;
        end else if (i_mode_load) begin
            r_manual  <= i_mode_value;
            r_pending <= 1'b0;
        end else if (i_en) begin
            r_manual    <= n_manual;
            r_pending   <= n_pending;
            r_pump      <= n_pump;
            r_auto_last <= n_auto_last;
        end
    end

endmodule

/* rtl/core/rpc_outbuf.sv */
// ----------------------------------------------------------------------------
// rpc_outbuf: result register with skid stage
// Holds results while the receiver stalls; stalls the input only when full.
// ----------------------------------------------------------------------------
module rpc_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rpc_pkg::t_out_item i_item,
    output logic               o_full,
    output logic               o_valid,
    output rpc_pkg::t_out_item o_item,
    input  logic               i_stall
);

    logic               r_out_valid;
    rpc_pkg::t_out_item r_out;
    logic               r_skid_valid;
    rpc_pkg::t_out_item r_skid;
    logic               out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_item;
            end
        end else if (i_push) begin
            r_skid <= i_item;
        end
    end

endmodule

/* rtl/core/reservoir_pump_controller.sv */
// ----------------------------------------------------------------------------
// reservoir_pump_controller: tick-driven reservoir pump controller
// Qualifies level and button pins per tick and issues pump commands.
// ----------------------------------------------------------------------------
// Input channel: one transfer per millisecond tick on i_in_valid/o_in_stall,
// carrying the raw level and button pins. Output channel: one result per
// tick on o_out_valid/i_out_stall with pump command, mode, qualified level,
// command report and start-inhibit flag.
// Each result is registered, in the result register or, while stalled, in the skid.
// Throughput: one tick per cycle while o_in_stall is low; the whole tick update is one pass of
// combinational logic from the state registers into the result register.
// A two-entry output (result register plus skid) lets the block take the
// next tick while a finished result waits; o_in_stall rises only when both
// entries are occupied, and stays low again once the receiver drains one.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data;
// write only while idle. Writing start_manual reloads the mode
// and clears a pending manual toggle. Unknown indexes are ignored.
// Reset (synchronous, active low): registers return to defaults (level
// threshold 2000, button threshold 50, AUTO mode, pump off), timers clear,
// the level reads unknown and both output entries empty.
// ----------------------------------------------------------------------------
module reservoir_pump_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  rpc_pkg::t_in_item                    i_in_data,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    output rpc_pkg::t_out_item                   o_out_data,
    input  logic                                 i_out_stall,
    input  logic                                 i_cfg_we,
    input  logic [rpc_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [rpc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    rpc_pkg::t_cfg      r_cfg;
    rpc_pkg::t_qual     qual;
    rpc_pkg::t_out_item result;
    logic               in_xfer;
    logic               full;
    logic               mode_load;

    // a tick transfers whenever the skid entry is free
    assign o_in_stall = full;
    assign in_xfer    = i_in_valid && !full;
    assign mode_load  = i_cfg_we && (i_cfg_index == rpc_pkg::REG_START_MANUAL);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_stable_ticks  <= rpc_pkg::LEVEL_STABLE_RESET;
            r_cfg.button_stable_ticks <= rpc_pkg::BUTTON_STABLE_RESET;
            r_cfg.well_assigned       <= 1'b0;
            r_cfg.well_shared         <= 1'b0;
            r_cfg.start_manual        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rpc_pkg::REG_LEVEL_STABLE:  r_cfg.level_stable_ticks  <= i_cfg_data;
                rpc_pkg::REG_BUTTON_STABLE: r_cfg.button_stable_ticks <= i_cfg_data;
                rpc_pkg::REG_WELL_ASSIGNED: r_cfg.well_assigned       <= i_cfg_data[0];
                rpc_pkg::REG_WELL_SHARED:   r_cfg.well_shared         <= i_cfg_data[0];
                rpc_pkg::REG_START_MANUAL:  r_cfg.start_manual        <= i_cfg_data[0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // level qualifier and button debouncer advance on each tick transfer
    rpc_qualify u_qualify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_xfer),
        .i_item  (i_in_data),
        .i_cfg   (r_cfg),
        .o_qual  (qual)
    );

    // mode and pump decisions, fed by this tick's qualified level and press
    rpc_control u_control (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_xfer),
        .i_qual       (qual),
        .i_cfg        (r_cfg),
        .i_mode_load  (mode_load),
        .i_mode_value (i_cfg_data[0]),
        .o_item       (result)
    );

    // result register and skid stage
    rpc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_item  (result),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .i_stall (i_out_stall)
    );

`ifndef NO_ASSERTIONS
    // a refused start leaves the pump off and happens only in manual mode
    a_inhibit_manual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.start_inhibited)
            |-> (!o_out_data.pump_on && o_out_data.mode_manual))
        else $error("start inhibit outside manual mode or with pump on");

    // no command is reported while no well is assigned
    a_send_needs_well: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !r_cfg.well_assigned) |-> (result.send_kind == rpc_pkg::SEND_NONE))
        else $error("command reported without an assigned well");

    // report codes and level codes stay in range
    a_codes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.send_kind <= rpc_pkg::SEND_SHARED &&
                         o_out_data.level_state <= rpc_pkg::LVL_FULL))
        else $error("illegal send or level code on output");

    // a tick transfer while the output is stalled fills the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && o_out_valid && i_out_stall) |=> full)
        else $error("stalled result lost a following tick");
`endif

endmodule
